// ===== sv/arm_import_stub_decoder_defines.svh =====
// Assertion helpers shared by the decoder modules.
`ifndef ARM_IMPORT_STUB_DECODER_DEFINES_SVH
`define ARM_IMPORT_STUB_DECODER_DEFINES_SVH

// Check cons in the same cycle as ante.
`define AISD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante.
`define AISD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/aisd_pkg.sv =====
package aisd_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned IMM_W  = 16;
	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [20:0] BX_PATTERN  = 21'h12FFF1;
	localparam logic [20:0] BLX_PATTERN = 21'h12FFF3;
	localparam logic [3:0]  COND_AL     = 4'hE;
	localparam logic [3:0]  REG_IP      = 4'hC;

	typedef enum logic [2:0] {
		CLS_UNKNOWN = 3'd0,
		CLS_MOV     = 3'd1,
		CLS_MOVT    = 3'd2,
		CLS_SVC     = 3'd3,
		CLS_BRANCH  = 3'd4
	} word_class_t;

	typedef enum logic [1:0] {
		KIND_NONE     = 2'd0,
		KIND_SYSCALL  = 2'd1,
		KIND_FUNCTION = 2'd2
	} stub_kind_t;

	typedef struct packed {
		word_class_t       cls;
		logic [IMM_W-1:0]  imm;
		logic [WORD_W-1:0] sym;
	} q_entry_t;

endpackage

// ===== sv/aisd_front.sv =====
module aisd_front
	import aisd_pkg::*;
(
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [WORD_W-1:0] instr_word,
	input  logic [WORD_W-1:0] symbol_id,
	input  logic              q_ready,
	output logic              push,
	output q_entry_t          entry
);

	logic [2:0]  op;
	logic [20:0] mid;
	word_class_t cls;

	assign op  = instr_word[27:25];
	assign mid = instr_word[24:4];

	always_comb begin
		cls = CLS_UNKNOWN;
		if (instr_word[31:28] == COND_AL) begin
			if (op[2]) begin
				if (instr_word[27:24] == 4'hF)
					cls = CLS_SVC;
			end else if (op == 3'b001) begin
				if (instr_word[24:23] == 2'b10 && instr_word[21:20] == 2'b00 &&
						instr_word[15:12] == REG_IP)
					cls = instr_word[22] ? CLS_MOVT : CLS_MOV;
			end else if (op == 3'b000) begin
				if (mid == BX_PATTERN || mid == BLX_PATTERN)
					cls = CLS_BRANCH;
			end
		end
	end

	assign s_tready  = q_ready;
	assign push      = s_tvalid && q_ready;
	assign entry.cls = cls;
	assign entry.imm = {instr_word[19:16], instr_word[11:0]};
	assign entry.sym = symbol_id;

endmodule

// ===== sv/aisd_queue.sv =====
`include "arm_import_stub_decoder_defines.svh"

module aisd_queue
	import aisd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t push_entry,
	output logic     push_ready,
	input  logic     pop,
	output logic     pop_valid,
	output q_entry_t pop_entry
);

	q_entry_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		logic [QPTR_W-1:0] r;
		if (p == QPTR_W'(QDEPTH - 1))
			r = '0;
		else
			r = QPTR_W'(p + 1'b1);
		return r;
	endfunction

	assign push_ready = (count_q != QCNT_W'(QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_entry  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop)
				count_q <= QCNT_W'(count_q + 1'b1);
			else if (pop && !push)
				count_q <= QCNT_W'(count_q - 1'b1);
		end
	end

	`AISD_ASSERT_SAME(a_q_no_underflow, clk, arst_n, pop, count_q != '0, "pop from empty queue")
	`AISD_ASSERT_SAME(a_q_no_overflow, clk, arst_n, 1'b1, count_q <= QCNT_W'(QDEPTH), "queue overfilled")

endmodule

// ===== sv/aisd_back.sv =====
`include "arm_import_stub_decoder_defines.svh"

module aisd_back
	import aisd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  q_entry_t          q_entry,
	output logic              pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output word_class_t       word_class,
	output logic              stub_done,
	output stub_kind_t        stub_kind,
	output logic [WORD_W-1:0] stub_value,
	output logic              stub_resolved,
	output logic [WORD_W-1:0] symbol_out
);

	logic [WORD_W-1:0] accum_q;
	logic [WORD_W-1:0] accum_upd;
	logic              done;
	stub_kind_t        kind;
	logic              out_valid_q;

	always_comb begin
		accum_upd = accum_q;
		done      = 1'b0;
		kind      = KIND_NONE;
		case (q_entry.cls)
			CLS_MOV:    accum_upd = {{(WORD_W-IMM_W){1'b0}}, q_entry.imm};
			CLS_MOVT:   accum_upd = accum_q | {q_entry.imm, {(WORD_W-IMM_W){1'b0}}};
			CLS_SVC: begin
				done = 1'b1;
				kind = KIND_SYSCALL;
			end
			CLS_BRANCH: begin
				done = 1'b1;
				kind = KIND_FUNCTION;
			end
			default: ;
		endcase
	end

	assign pop      = q_valid && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				accum_q     <= done ? '0 : accum_upd;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			word_class    <= q_entry.cls;
			stub_done     <= done;
			stub_kind     <= kind;
			stub_value    <= accum_upd;
			stub_resolved <= done && (accum_upd != '0);
			symbol_out    <= q_entry.sym;
		end
	end

	`AISD_ASSERT_NEXT(a_clear_after_end, clk, arst_n, pop && done, accum_q == '0, "accumulator kept after stub end")
	`AISD_ASSERT_SAME(a_resolved_ok, clk, arst_n, out_valid_q && stub_resolved, stub_done && (stub_value != '0), "resolved without done or value")

endmodule

// ===== sv/arm_import_stub_decoder.sv =====
// ARM import stub decoder.
// Input channel s_axis: one beat per 32-bit instruction word of a stub, with the
// stub's symbol id alongside. Output channel m_axis: exactly one beat per input
// beat, in order, carrying the decoded class, the accumulated immediate value and
// the symbol id. tlast marks the word that ends a stub (SVC, BX or BLX); on that
// beat tuser also gives the stub kind and tdata bit 32 is set when the value is
// nonzero, and the accumulator is cleared for the next stub.
// A result beat passes from the two-entry queue behind the classifier into the
// output register before it turns valid on m_axis. Throughput: one word per
// cycle while m_axis_tready stays high, set by the single accumulator update in
// the back end.
// Reset clears the queue, the output valid and the accumulator; s_axis_tready
// rises right away. When m_axis_tready is low the output register holds its beat
// and the queue absorbs up to two more words before s_axis_tready drops.
module arm_import_stub_decoder
	import aisd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // instr_word[31:0], symbol_id[63:32]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,  // stub_value[31:0], stub_resolved[32], symbol_out[64:33], 0
	output logic        m_axis_tlast,  // stub_done
	output logic [4:0]  m_axis_tuser   // word_class[2:0], stub_kind[4:3]
);

	logic              q_ready;
	logic              push;
	q_entry_t          push_entry;
	logic              q_valid;
	logic              pop;
	q_entry_t          pop_entry;
	word_class_t       word_class;
	stub_kind_t        stub_kind;
	logic [WORD_W-1:0] stub_value;
	logic              stub_resolved;
	logic [WORD_W-1:0] symbol_out;

	aisd_front u_front (
		.s_tvalid   (s_axis_tvalid),
		.s_tready   (s_axis_tready),
		.instr_word (s_axis_tdata[31:0]),
		.symbol_id  (s_axis_tdata[63:32]),
		.q_ready    (q_ready),
		.push       (push),
		.entry      (push_entry)
	);

	aisd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.push_ready (q_ready),
		.pop        (pop),
		.pop_valid  (q_valid),
		.pop_entry  (pop_entry)
	);

	aisd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_entry       (pop_entry),
		.pop           (pop),
		.m_tvalid      (m_axis_tvalid),
		.m_tready      (m_axis_tready),
		.word_class    (word_class),
		.stub_done     (m_axis_tlast),
		.stub_kind     (stub_kind),
		.stub_value    (stub_value),
		.stub_resolved (stub_resolved),
		.symbol_out    (symbol_out)
	);

	assign m_axis_tdata = {7'b0, symbol_out, stub_resolved, stub_value};
	assign m_axis_tuser = {stub_kind, word_class};

endmodule
